FILE: design/cfd_pkg.sv
// shared types and constants for the cell change detector
// no dependencies; imported by cfd_sum and the core top level
package cfd_pkg;

  // configuration register indexes
  localparam logic [0:0] CFG_COLUMNS    = 1'd0;
  localparam logic [0:0] CFG_CELL_COUNT = 1'd1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [4:0] COLUMNS_RESET    = 5'd5;
  localparam logic [4:0] CELL_COUNT_RESET = 5'd16;

  localparam logic [8:0] FL_MOD = 9'd255;

  // running fletcher sums, sum_two is the high byte of the checksum
  typedef struct packed {
    logic [7:0] sum_two;
    logic [7:0] sum_one;
  } sums_t;

endpackage

FILE: design/cell_change_detector_fletcher16_core.sv
// cell change detector: fletcher-16 over the bytes of a cell, compared against a slot table
// depends on cfd_pkg and cfd_sum
//
// Input channel (in_valid/in_ready) carries one pixel byte per item with the
// cell's row and column; last_byte closes the cell. Only a last byte yields a
// result item on the output channel (out_valid/out_ready): the slot
// (row*columns + columns - col, low eight bits), the checksum, and the
// changed/rejected flags. Bytes are taken one per cycle, with no gaps unless the output stalls.
// A last byte's result passes through the compare stage into the output register:
// the synchronous read of the checksum table is taken at the accepting edge, and
// the compare and write-back load the output register when the compare stage
// advances. The table write-back happens as that stage advances, so a write to the
// same slot by the preceding cell is forwarded into the compare.
// When the receiver stalls, the output register and the compare stage hold
// and in_ready drops once both are full; nothing is dropped.
// Reset clears the running sums, loads columns=5 and cell_count=16, and marks
// every table entry as zero through per-entry valid bits, so there is no
// clearing pass. Configuration writes (cfg_we, cfg_index, cfg_data) are meant
// for an idle block.
module cell_change_detector_fletcher16_core
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            cell_row,
  input  logic [3:0]            cell_col,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            slot_index,
  output logic [15:0]           checksum,
  output logic                  changed,
  output logic                  rejected
);

  localparam int unsigned IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [9:0]  MAX_L = 10'(MAX_CELLS);

  logic [4:0] columns;
  logic [4:0] cell_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= COLUMNS_RESET;
      cell_count <= CELL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS:    columns    <= cfg_data;
        CFG_CELL_COUNT: cell_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic in_acc;
  logic close_acc;
  logic out_free;
  logic s1_full;
  logic s1_adv;

  assign out_free  = !out_valid || out_ready;
  assign s1_adv    = s1_full && out_free;
  assign in_ready  = !s1_full || out_free;
  assign in_acc    = in_valid && in_ready;
  assign close_acc = in_acc && last_byte;

  sums_t sums_next;

  cfd_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .step      (in_acc),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .sums_next (sums_next)
  );

  // slot arithmetic, exact without wrapping
  logic [9:0]       base;
  logic [9:0]       diff;
  logic             neg;
  logic             in_range;
  logic [IDX_W-1:0] rd_idx;

  always_comb begin
    base     = 10'({1'b0, cell_row} + 5'd1) * 10'(columns);
    neg      = {6'd0, cell_col} > base;
    diff     = base - {6'd0, cell_col};
    in_range = !neg && (diff < {5'd0, cell_count}) && (diff < MAX_L);
    rd_idx   = in_range ? diff[IDX_W-1:0] : '0;
  end

  // compare stage
  logic [7:0]       s1_slot;
  logic [15:0]      s1_chk;
  logic             s1_in_range;
  logic [IDX_W-1:0] s1_idx;
  logic [15:0]      rd_data;
  logic             rd_vld;
  logic             fwd_hit;
  logic [15:0]      fwd_data;
  logic [15:0]      s1_stored;
  logic             s1_diff;
  logic             wr_en;

  logic [15:0]          mem [MAX_CELLS];
  logic [MAX_CELLS-1:0] vld;

  assign s1_stored = fwd_hit ? fwd_data : (rd_vld ? rd_data : 16'd0);
  assign s1_diff   = s1_stored != s1_chk;
  assign wr_en     = s1_adv && s1_in_range && s1_diff;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= s1_chk;
    end
    if (close_acc) begin
      rd_data  <= mem[rd_idx];
      rd_vld   <= vld[rd_idx];
      // same slot written at this edge by the previous cell
      fwd_hit  <= wr_en && (s1_idx == rd_idx);
      fwd_data <= s1_chk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
    end else if (close_acc) begin
      s1_full <= 1'b1;
    end else if (s1_adv) begin
      s1_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close_acc) begin
      s1_slot     <= diff[7:0];
      s1_chk      <= sums_next;
      s1_in_range <= in_range;
      s1_idx      <= rd_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      slot_index <= s1_slot;
      checksum   <= s1_chk;
      changed    <= s1_in_range && s1_diff;
      rejected   <= !s1_in_range;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(changed && rejected))
    else $error("changed and rejected both set");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_full && !out_free) |=> (s1_full && $stable(s1_chk) && $stable(s1_idx)))
    else $error("compare stage lost its item under stall");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vld[$past(s1_idx)])
    else $error("table write did not mark the entry valid");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_full && out_valid))
    else $error("input stalled with room in the pipeline");

endmodule

FILE: design/cfd_sum.sv
// running fletcher-16 sums, both modulo 255, cleared after the last byte of a cell
// depends on cfd_pkg
module cfd_sum
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output sums_t      sums_next
);

  logic [7:0] sum_one;
  logic [7:0] sum_two;

  function automatic logic [7:0] add_mod(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= FL_MOD) begin
      s = s - FL_MOD;
    end
    return s[7:0];
  endfunction

  always_comb begin
    sums_next.sum_one = add_mod(sum_one, data_byte);
    sums_next.sum_two = add_mod(sum_two, sums_next.sum_one);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_one <= '0;
      sum_two <= '0;
    end else if (step) begin
      if (last_byte) begin
        sum_one <= '0;
        sum_two <= '0;
      end else begin
        sum_one <= sums_next.sum_one;
        sum_two <= sums_next.sum_two;
      end
    end
  end

endmodule
